@@ src/dcpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dcpm_pkg
// Types and constants for the DMA channel ping-pong manager.
// ----------------------------------------------------------------------------
package dcpm_pkg;

    localparam int NUM_CHANNELS_DEF = 6;

    localparam int REQ_W   = 2;
    localparam int CH_W    = 3;
    localparam int STAT_W  = 8;
    localparam int DEV_W   = 4;
    localparam int PORT_W  = 25;
    localparam int ADDR_W  = 32;
    localparam int BCNT_W  = 14;
    localparam int CNT_W   = 13;
    localparam int CODE_W  = 3;
    localparam int QCNT_W  = 2;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 104;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_START = 2'd2,
        REQ_IRQ   = 2'd3
    } req_t;

    typedef enum logic [CODE_W-1:0] {
        RES_OK       = 3'd0,
        RES_NO_CHAN  = 3'd1,
        RES_BOTH_Q   = 3'd2,
        RES_BUSY     = 3'd3,
        RES_SPURIOUS = 3'd4
    } res_code_t;

    // status register bits
    localparam int ST_RUN   = 0;
    localparam int ST_IE    = 1;
    localparam int ST_ERR   = 2;
    localparam int ST_DONEA = 3;
    localparam int ST_STRTA = 4;
    localparam int ST_DONEB = 5;
    localparam int ST_STRTB = 6;
    localparam int ST_BIU   = 7;

    localparam logic [STAT_W-1:0] MASK_ALL     = 8'hff;
    localparam logic [STAT_W-1:0] MASK_DONEA   = 8'h08;
    localparam logic [STAT_W-1:0] MASK_DONEB   = 8'h20;
    localparam logic [STAT_W-1:0] CLR_A        = 8'h18;
    localparam logic [STAT_W-1:0] SET_A        = 8'h13;
    localparam logic [STAT_W-1:0] CLR_B        = 8'h60;
    localparam logic [STAT_W-1:0] SET_B        = 8'h43;
    localparam logic [ADDR_W-1:0] DDAR_ENABLE  = 32'h8000_0000;
    localparam logic [QCNT_W-1:0] QCNT_FULL    = 2'd2;
    localparam logic [QCNT_W-1:0] QCNT_TOP     = 2'd3;

    typedef struct packed {
        logic               error_seen;
        logic [QCNT_W-1:0]  handler_arg;
        logic [CNT_W-1:0]   count_minus_one;
        logic [ADDR_W-1:0]  address_out;
        logic               use_buffer_b;
        logic [STAT_W-1:0]  set_mask;
        logic [STAT_W-1:0]  clear_mask;
        logic [ADDR_W-1:0]  ddar_value;
        logic [CH_W-1:0]    channel_out;
    } result_t;

endpackage : dcpm_pkg
`default_nettype wire

@@ src/dma_channel_pingpong_manager_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dma_channel_pingpong_manager_core
// Allocation and ping-pong buffer bookkeeping for a set of DMA channels.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel carries one request word: tuser is the request kind
//   (allocate, free, start buffer, completion interrupt), tdata the channel,
//   the status read from hardware and the allocate/start arguments.
//   The m_axis channel returns exactly one result word per request: tuser is
//   the result code, tdata the channel, the device address word, the clear
//   and set masks, the buffer choice, the address and count for the buffer,
//   the handler argument and the error flag.
//   A request is captured in an input register and resolved by one level of
//   logic into the output register, which drives m_axis_tvalid; one word per
//   cycle is sustained while the receiver does not stall. The channel state
//   (allocated flags, queued buffer counts) is updated as a word moves into
//   the output register, so each word sees the effect of the one before.
//   When the receiver stalls, the output register holds its word and one
//   more word waits in the input register; s_axis_tready then falls.
//   Reset frees every channel and clears all queued counts; no word is
//   pending afterward.
// ----------------------------------------------------------------------------
module dma_channel_pingpong_manager_core #(
    parameter int NUM_CHANNELS = dcpm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, from bit 0: channel, status, read_dir, big_endian,
    // burst_is_eight, datum_is_two, device, port, buffer_address, byte_count
    input  wire logic [dcpm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  wire logic [dcpm_pkg::REQ_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata, from bit 0: channel_out, ddar_value, clear_mask, set_mask,
    // use_buffer_b, address_out, count_minus_one, handler_arg, error_seen
    output logic [dcpm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: result_code
    output logic [dcpm_pkg::CODE_W-1:0]         m_axis_tuser
);
    import dcpm_pkg::*;

    localparam int RES_W = $bits(result_t);

    logic                  in_valid_reg;
    logic [S_TDATA_W-1:0]  in_data_reg;
    logic [REQ_W-1:0]      in_req_reg;
    logic                  out_valid_reg;
    result_t               out_res_reg;
    result_t               res_next;
    logic [CODE_W-1:0]     out_code_reg;
    logic [CODE_W-1:0]     code_next;

    logic                  alloc_reg [NUM_CHANNELS];
    logic                  alloc_next [NUM_CHANNELS];
    logic [QCNT_W-1:0]     queue_reg [NUM_CHANNELS];
    logic [QCNT_W-1:0]     queue_next [NUM_CHANNELS];

    logic                  advance;

    // unpacked request fields
    logic [CH_W-1:0]       f_ch;
    logic [STAT_W-1:0]     f_st;
    logic [3:0]            f_flags;
    logic [DEV_W-1:0]      f_dev;
    logic [PORT_W-1:0]     f_port;
    logic [ADDR_W-1:0]     f_addr;
    logic [BCNT_W-1:0]     f_bcnt;

    logic                  ch_in_range;
    logic [QCNT_W-1:0]     ch_queue;
    logic                  free_found;
    logic [CH_W-1:0]       free_idx;
    logic                  use_a;
    logic                  done_bit;
    logic [BCNT_W-1:0]     bcnt_m1;
    logic                  q_ok;

    assign f_ch    = in_data_reg[2:0];
    assign f_st    = in_data_reg[10:3];
    assign f_flags = in_data_reg[14:11];
    assign f_dev   = in_data_reg[18:15];
    assign f_port  = in_data_reg[43:19];
    assign f_addr  = in_data_reg[75:44];
    assign f_bcnt  = in_data_reg[89:76];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // addressed channel lookup and lowest free channel
    always_comb begin
        ch_in_range = (int'(f_ch) < NUM_CHANNELS);
        ch_queue    = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (int'(f_ch) == k) begin
                ch_queue = queue_reg[k];
            end
        end
        for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
            if (!alloc_reg[k]) begin
                free_found = 1'b1;
                free_idx   = CH_W'(k);
            end
        end
    end

    assign use_a = (f_st[ST_BIU] && f_st[ST_STRTB]) || (!f_st[ST_BIU] && !f_st[ST_STRTA]);
    assign done_bit = f_st[ST_BIU] ? f_st[ST_DONEA] : f_st[ST_DONEB];
    assign bcnt_m1  = f_bcnt - BCNT_W'(1);

    // result and state update
    always_comb begin
        res_next             = '0;
        res_next.channel_out = f_ch;
        code_next            = RES_OK;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            alloc_next[k] = alloc_reg[k];
            queue_next[k] = queue_reg[k];
        end
        case (req_t'(in_req_reg))
            REQ_ALLOC: begin
                if (!free_found) begin
                    code_next            = RES_NO_CHAN;
                    res_next.channel_out = '0;
                end else begin
                    res_next.channel_out = free_idx;
                    // port and device overlap at bits 7:6; fields are ORed
                    res_next.ddar_value  = DDAR_ENABLE | {1'b0, f_port, 6'b0} |
                                           {24'b0, f_dev, 4'b0} | {28'b0, f_flags};
                    res_next.clear_mask  = MASK_ALL;
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        if (CH_W'(k) == free_idx && free_found) begin
                            alloc_next[k] = 1'b1;
                        end
                    end
                end
            end
            REQ_FREE: begin
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    if (int'(f_ch) == k) begin
                        alloc_next[k] = 1'b0;
                    end
                end
            end
            REQ_START: begin
                if (!ch_in_range || ch_queue >= QCNT_FULL) begin
                    code_next = RES_BOTH_Q;
                end else if (f_st[ST_RUN] && !f_st[ST_DONEA] && !f_st[ST_DONEB]) begin
                    code_next = RES_BUSY;
                end else begin
                    res_next.clear_mask      = use_a ? CLR_A : CLR_B;
                    res_next.set_mask        = use_a ? SET_A : SET_B;
                    res_next.use_buffer_b    = !use_a;
                    res_next.address_out     = f_addr;
                    res_next.count_minus_one = bcnt_m1[CNT_W-1:0];
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        if (int'(f_ch) == k) begin
                            queue_next[k] = queue_reg[k] + QCNT_W'(1);
                        end
                    end
                end
            end
            REQ_IRQ: begin
                res_next.error_seen = f_st[ST_ERR];
                if (!ch_in_range || !done_bit) begin
                    code_next = RES_SPURIOUS;
                end else begin
                    res_next.clear_mask   = f_st[ST_BIU] ? MASK_DONEA : MASK_DONEB;
                    res_next.use_buffer_b = !f_st[ST_BIU];
                    res_next.handler_arg  = QCNT_TOP - ch_queue;
                    for (int k = 0; k < NUM_CHANNELS; k++) begin
                        if (int'(f_ch) == k && queue_reg[k] != '0) begin
                            queue_next[k] = queue_reg[k] - QCNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                code_next = RES_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                alloc_reg[k] <= 1'b0;
                queue_reg[k] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    alloc_reg[k] <= alloc_next[k];
                    queue_reg[k] <= queue_next[k];
                end
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
            in_req_reg  <= s_axis_tuser;
        end
        if (advance) begin
            out_res_reg  <= res_next;
            out_code_reg <= code_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - RES_W)'(0), out_res_reg};
    assign m_axis_tuser  = out_code_reg;

    always_comb begin
        q_ok = 1'b1;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (queue_reg[k] > QCNT_FULL) begin
                q_ok = 1'b0;
            end
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn) q_ok)
        else $error("queued buffer count above two");

    a_pending_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending request lost while output stalled");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("resolved request gave no result word");

    a_no_chan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == RES_NO_CHAN |-> out_res_reg.channel_out == '0)
        else $error("failed allocate reports a channel");

endmodule : dma_channel_pingpong_manager_core
`default_nettype wire

@@ sim/dma_channel_pingpong_manager_core_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dma_channel_pingpong_manager_core_test
// Self-checking bench for the DMA channel ping-pong manager. A short table of
// directed requests covers allocation up to exhaustion, free, buffer start in
// both buffer choices, the refusal and busy codes, real and spurious
// interrupts and out-of-range channels. Constrained-by-hand random traffic
// follows in four flow-control phases. Every result word is compared field by
// field against a behavioral model of channel bookkeeping or the table row.
// ----------------------------------------------------------------------------
module dma_channel_pingpong_manager_core_test;

    import dcpm_pkg::*;

    localparam int NUM_CH      = NUM_CHANNELS_DEF;
    localparam int DIR_ROWS    = 26;
    localparam int PHASE_ITEMS = 430;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 40;

    // request payload, packed from bit 0 exactly as s_axis_tdata
    typedef struct packed {
        logic [BCNT_W-1:0] bcnt;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [DEV_W-1:0]  dev;
        logic              d2;
        logic              b8;
        logic              be;
        logic              rd;
        logic [STAT_W-1:0] st;
        logic [CH_W-1:0]   ch;
    } req_data_t;

    typedef struct packed {
        res_code_t code;
        result_t   res;
    } outcome_t;

    // cfg holds {port, device, datum_is_two, burst_is_eight, big_endian, read_dir}
    typedef struct packed {
        req_t              req;
        logic [CH_W-1:0]   ch;
        logic [STAT_W-1:0] st;
        logic [32:0]       cfg;
        logic [ADDR_W-1:0] addr;
        logic [BCNT_W-1:0] bcnt;
        logic              typed;
        res_code_t         code;
        logic [CH_W-1:0]   xch;
        logic [ADDR_W-1:0] xddar;
        logic [STAT_W-1:0] xclr;
        logic              xerr;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [REQ_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [CODE_W-1:0]    m_axis_tuser;

    logic                 chan_busy [NUM_CH];
    logic [QCNT_W-1:0]    queued_cnt [NUM_CH];
    outcome_t             pending_results [$];
    int                   src_idle_pct;
    int                   snk_stall_pct;
    int                   mismatch_count;
    int                   words_checked;
    int                   cycle_count;
    int                   reqs_sent [4];
    int                   codes_seen [5];
    dir_row_t             dir_tab [DIR_ROWS];

    dma_channel_pingpong_manager_core #(
        .NUM_CHANNELS(NUM_CH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic outcome_t resolve_request(input req_t req, input req_data_t d);
        outcome_t          o;
        int                found;
        logic              use_a;
        logic              fin_a;
        logic [QCNT_W-1:0] q;
        o = '0;
        o.code = RES_OK;
        o.res.channel_out = d.ch;
        case (req)
            REQ_ALLOC: begin
                found = -1;
                for (int k = 0; k < NUM_CH; k++) begin
                    if (!chan_busy[k] && found < 0) found = k;
                end
                if (found < 0) begin
                    o.code = RES_NO_CHAN;
                    o.res.channel_out = '0;
                end else begin
                    chan_busy[found] = 1'b1;
                    o.res.channel_out = CH_W'(found);
                    o.res.ddar_value = DDAR_ENABLE | {1'b0, d.port, 6'b0} |
                        {24'b0, d.dev, 4'b0} | {28'b0, d.d2, d.b8, d.be, d.rd};
                    o.res.clear_mask = MASK_ALL;
                end
            end
            REQ_FREE: begin
                if (d.ch < NUM_CH) chan_busy[d.ch] = 1'b0;
            end
            REQ_START: begin
                if (d.ch >= NUM_CH || queued_cnt[d.ch] >= QCNT_FULL) begin
                    o.code = RES_BOTH_Q;
                end else if (d.st[ST_RUN] && !d.st[ST_DONEA] && !d.st[ST_DONEB]) begin
                    o.code = RES_BUSY;
                end else begin
                    use_a = (d.st[ST_BIU] && d.st[ST_STRTB]) ||
                            (!d.st[ST_BIU] && !d.st[ST_STRTA]);
                    o.res.clear_mask = use_a ? CLR_A : CLR_B;
                    o.res.set_mask = use_a ? SET_A : SET_B;
                    o.res.use_buffer_b = !use_a;
                    o.res.address_out = d.addr;
                    o.res.count_minus_one = CNT_W'(d.bcnt - 14'd1);
                    queued_cnt[d.ch] = queued_cnt[d.ch] + 2'd1;
                end
            end
            default: begin
                fin_a = d.st[ST_BIU];
                o.res.error_seen = d.st[ST_ERR];
                if (d.ch >= NUM_CH || !(fin_a ? d.st[ST_DONEA] : d.st[ST_DONEB])) begin
                    o.code = RES_SPURIOUS;
                end else begin
                    q = queued_cnt[d.ch];
                    o.res.clear_mask = fin_a ? MASK_DONEA : MASK_DONEB;
                    o.res.use_buffer_b = !fin_a;
                    o.res.handler_arg = QCNT_TOP - q;
                    if (q != '0) queued_cnt[d.ch] = q - 2'd1;
                end
            end
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch on result word %0d: %s got 0x%0h, expected 0x%0h",
                     words_checked, field, got, want);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input req_t req, input req_data_t d);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= S_TDATA_W'(d);
        do @(posedge aclk); while (!s_axis_tready);
        reqs_sent[req]++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= (snk_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        outcome_t want;
        result_t  got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing expected", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                codes_seen[want.code]++;
                if (m_axis_tuser !== want.code)
                    report_mismatch("result_code", 32'(m_axis_tuser), 32'(want.code));
                if (got.channel_out !== want.res.channel_out)
                    report_mismatch("channel_out", 32'(got.channel_out),
                                    32'(want.res.channel_out));
                if (got.ddar_value !== want.res.ddar_value)
                    report_mismatch("ddar_value", got.ddar_value, want.res.ddar_value);
                if (got.clear_mask !== want.res.clear_mask)
                    report_mismatch("clear_mask", 32'(got.clear_mask),
                                    32'(want.res.clear_mask));
                if (got.set_mask !== want.res.set_mask)
                    report_mismatch("set_mask", 32'(got.set_mask), 32'(want.res.set_mask));
                if (got.use_buffer_b !== want.res.use_buffer_b)
                    report_mismatch("use_buffer_b", 32'(got.use_buffer_b),
                                    32'(want.res.use_buffer_b));
                if (got.address_out !== want.res.address_out)
                    report_mismatch("address_out", got.address_out, want.res.address_out);
                if (got.count_minus_one !== want.res.count_minus_one)
                    report_mismatch("count_minus_one", 32'(got.count_minus_one),
                                    32'(want.res.count_minus_one));
                if (got.handler_arg !== want.res.handler_arg)
                    report_mismatch("handler_arg", 32'(got.handler_arg),
                                    32'(want.res.handler_arg));
                if (got.error_seen !== want.res.error_seen)
                    report_mismatch("error_seen", 32'(got.error_seen),
                                    32'(want.res.error_seen));
            end
            words_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        req_data_t   d;
        outcome_t    want;
        logic [95:0] rnd;
        req_t        req;
        int          pick;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = REQ_ALLOC;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        mismatch_count = 0;
        words_checked  = 0;
        cycle_count    = 0;
        for (int k = 0; k < NUM_CH; k++) begin
            chan_busy[k]  = 1'b0;
            queued_cnt[k] = '0;
        end
        for (int k = 0; k < 4; k++) reqs_sent[k] = 0;
        for (int k = 0; k < 5; k++) codes_seen[k] = 0;

        dir_tab = '{
            '{REQ_ALLOC, 0, 'h00, 0, 0, 0, 1, RES_OK, 0, 'h8000_0000, 'hff, 0},
            '{REQ_ALLOC, 7, 'hff, 33'h1_ffff_ffff, 'hffff_ffff, 'h3fff,
              1, RES_OK, 1, 'hffff_ffff, 'hff, 0},
            '{REQ_ALLOC, 0, 'h00, 'h0000_0155, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_ALLOC, 0, 'h00, 'h1234_5678, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_ALLOC, 0, 'h00, 'h2aaa_aaaa, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_ALLOC, 0, 'h00, 'h5555_5555, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            // all six taken
            '{REQ_ALLOC, 5, 'h00, 'h0000_0001, 0, 0, 1, RES_NO_CHAN, 0, 0, 0, 0},
            '{REQ_FREE,  3, 'h00, 0, 0, 0, 1, RES_OK, 3, 0, 0, 0},
            '{REQ_FREE,  7, 'hff, 0, 0, 0, 1, RES_OK, 7, 0, 0, 0},
            '{REQ_ALLOC, 0, 'h00, 'h0765_4321, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_START, 0, 'h00, 0, 0, 1, 0, RES_OK, 0, 0, 0, 0},
            // zero byte count wraps to 8191
            '{REQ_START, 0, 'hc0, 0, 'hffff_ffff, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_START, 0, 'h00, 0, 0, 1, 1, RES_BOTH_Q, 0, 0, 0, 0},
            '{REQ_START, 1, 'h01, 0, 0, 1, 1, RES_BUSY, 1, 0, 0, 0},
            '{REQ_START, 1, 'h10, 0, 'ha5a5_a5a5, 'h2000, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_START, 1, 'h80, 0, 'h5a5a_5a5a, 'h3fff, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_START, 6, 'h00, 0, 0, 1, 1, RES_BOTH_Q, 6, 0, 0, 0},
            '{REQ_IRQ,   0, 'h88, 0, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_IRQ,   0, 'h24, 0, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            // nothing queued any more: count stays at zero
            '{REQ_IRQ,   0, 'h20, 0, 0, 0, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_IRQ,   2, 'h08, 0, 0, 0, 1, RES_SPURIOUS, 2, 0, 0, 0},
            '{REQ_IRQ,   7, 'hff, 0, 0, 0, 1, RES_SPURIOUS, 7, 0, 0, 1},
            '{REQ_FREE,  4, 'h00, 0, 0, 0, 1, RES_OK, 4, 0, 0, 0},
            // start on a released channel
            '{REQ_START, 4, 'h29, 0, 'h0000_0004, 2, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_START, 4, 'h7f, 0, 'h8000_0000, 'h1fff, 0, RES_OK, 0, 0, 0, 0},
            '{REQ_ALLOC, 0, 'h00, 'h7fff_ffff, 0, 0, 0, RES_OK, 0, 0, 0, 0}
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            d = '0;
            d.ch   = dir_tab[r].ch;
            d.st   = dir_tab[r].st;
            {d.port, d.dev, d.d2, d.b8, d.be, d.rd} = dir_tab[r].cfg;
            d.addr = dir_tab[r].addr;
            d.bcnt = dir_tab[r].bcnt;
            send_word(dir_tab[r].req, d);
            want = resolve_request(dir_tab[r].req, d);
            if (dir_tab[r].typed) begin
                want = '0;
                want.code = dir_tab[r].code;
                want.res.channel_out = dir_tab[r].xch;
                want.res.ddar_value = dir_tab[r].xddar;
                want.res.clear_mask = dir_tab[r].xclr;
                want.res.error_seen = dir_tab[r].xerr;
            end
            pending_results.push_back(want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            src_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 37 : 0;
            snk_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 37 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rnd = {$urandom, $urandom, $urandom};
                d = rnd[$bits(req_data_t)-1:0];
                if ($urandom_range(99) < 88) d.ch = CH_W'($urandom_range(NUM_CH - 1));
                if ($urandom_range(99) < 85) d.bcnt = BCNT_W'($urandom_range(8192, 1));
                pick = $urandom_range(99);
                if (pick < 14) req = REQ_ALLOC;
                else if (pick < 24) req = REQ_FREE;
                else if (pick < 64) req = REQ_START;
                else req = REQ_IRQ;
                // mostly well-formed: starts not busy, interrupts with the done bit
                if (req == REQ_START && $urandom_range(99) < 75 &&
                    d.st[ST_RUN] && !d.st[ST_DONEA] && !d.st[ST_DONEB])
                    d.st[ST_RUN] = 1'b0;
                if (req == REQ_IRQ && $urandom_range(99) < 75) begin
                    if (d.st[ST_BIU]) d.st[ST_DONEA] = 1'b1;
                    else d.st[ST_DONEB] = 1'b1;
                end
                send_word(req, d);
                pending_results.push_back(resolve_request(req, d));
                if ($urandom_range(199) == 0) drain_results();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("%0d words: %0d allocate, %0d free, %0d start, %0d interrupt",
                 words_checked, reqs_sent[REQ_ALLOC], reqs_sent[REQ_FREE],
                 reqs_sent[REQ_START], reqs_sent[REQ_IRQ]);
        $display("codes: %0d ok, %0d no channel, %0d both queued, %0d busy, %0d spurious",
                 codes_seen[RES_OK], codes_seen[RES_NO_CHAN], codes_seen[RES_BOTH_Q],
                 codes_seen[RES_BUSY], codes_seen[RES_SPURIOUS]);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule : dma_channel_pingpong_manager_core_test
`default_nettype wire
